// ===== rtl/hes_pkg.sv =====
// Shared types, constants and helper functions for the Hamming encoder / syndrome block.
package hes_pkg;

	localparam int WORD_W   = 63;  // codeword positions 1..63
	localparam int DATA_CAP = 57;  // most data bits a 63-bit word can carry
	localparam int SYN_W    = 6;   // one check bit per address bit of a position
	localparam int PCNT_W   = 3;
	localparam int LEN_W    = 6;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_CHECK  = 1'b1;

	typedef struct packed {
		logic [DATA_CAP-1:0] data_mask;    // ones over the n data bits in use
		logic [WORD_W-1:0]   word_mask;    // ones over positions 1..n+p
		logic [PCNT_W-1:0]   parity_count; // p
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] code_word;
		logic [SYN_W-1:0]  syndrome;
		logic              error_found;
		logic [PCNT_W-1:0] parity_count;
	} res_t;

	// Smallest p in 1..6 with 2^p >= n + p + 1.
	function automatic logic [PCNT_W-1:0] parity_bits(input logic [LEN_W-1:0] n);
		logic [PCNT_W-1:0] p;
		logic              done;
		p    = PCNT_W'(1);
		done = 1'b0;
		for (int i = 1; i < SYN_W; i++) begin
			if (!done && ((8'd1 << p) < (8'(n) + 8'(p) + 8'd1))) begin
				p = p + PCNT_W'(1);
			end else begin
				done = 1'b1;
			end
		end
		return p;
	endfunction

	// Masks and parity count for an already clamped data length.
	function automatic cfg_t derive(input logic [LEN_W-1:0] n);
		cfg_t              c;
		logic [LEN_W-1:0]  total;
		c.parity_count = parity_bits(n);
		total          = n + LEN_W'(c.parity_count);
		c.data_mask    = {DATA_CAP{1'b1}} >> (LEN_W'(DATA_CAP) - n);
		c.word_mask    = {WORD_W{1'b1}} >> (LEN_W'(WORD_W) - total);
		return c;
	endfunction

	// Positions (bit k-1 = position k) whose index has bit i set.
	function automatic logic [WORD_W-1:0] check_mask(input int i);
		logic [WORD_W-1:0] m;
		for (int k = 1; k <= WORD_W; k++) begin
			m[k-1] = ((k >> i) & 1) != 0;
		end
		return m;
	endfunction

endpackage

// ===== rtl/hes_cfg.sv =====
// Data length register: clamps the written length and keeps the derived masks and parity count.
module hes_cfg #(
	parameter int MAX_DATA_BITS = 57
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [hes_pkg::LEN_W-1:0] cfg_wdata,
	output hes_pkg::cfg_t             cfg
);

	localparam logic [hes_pkg::LEN_W-1:0] MaxLen = hes_pkg::LEN_W'(MAX_DATA_BITS);
	// reset length is the cap, MAX_DATA_BITS (57 by default)
	localparam hes_pkg::cfg_t CfgRst = hes_pkg::derive(MaxLen);

	logic [hes_pkg::LEN_W-1:0] len_eff;
	hes_pkg::cfg_t             cfg_q;

	always_comb begin
		if (cfg_wdata == '0) begin
			len_eff = hes_pkg::LEN_W'(1);
		end else if (cfg_wdata > MaxLen) begin
			len_eff = MaxLen;
		end else begin
			len_eff = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgRst;
		end else if (cfg_wen) begin
			cfg_q <= hes_pkg::derive(len_eff);
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hes_core.sv =====
// Combinational encode / syndrome datapath sharing one set of parity trees.
module hes_core (
	input  logic                       cmd,
	input  logic [hes_pkg::WORD_W-1:0] payload,
	input  hes_pkg::cfg_t              cfg,
	output hes_pkg::res_t              res
);

	logic [hes_pkg::DATA_CAP-1:0] data;
	logic [hes_pkg::WORD_W-1:0]   spread;
	logic [hes_pkg::WORD_W-1:0]   word;
	logic [hes_pkg::SYN_W-1:0]    chk;
	logic [hes_pkg::WORD_W-1:0]   par_pos;

	assign data = payload[hes_pkg::DATA_CAP-1:0] & cfg.data_mask;

	// data bits go, lowest first, to positions that are not powers of two
	always_comb begin
		int d;
		spread = '0;
		d      = 0;
		for (int k = 1; k <= hes_pkg::WORD_W; k++) begin
			if ((k & (k - 1)) != 0 && d < hes_pkg::DATA_CAP) begin
				spread[k-1] = data[d];
				d           = d + 1;
			end
		end
	end

	// encode: parity slots are still zero, so the checks give the parity bits
	assign word = (cmd == hes_pkg::CMD_CHECK) ? (payload & cfg.word_mask) : spread;

	always_comb begin
		par_pos = '0;
		for (int i = 0; i < hes_pkg::SYN_W; i++) begin
			chk[i]              = ^(word & hes_pkg::check_mask(i));
			par_pos[(1 << i)-1] = chk[i];
		end
	end

	always_comb begin
		res.parity_count = cfg.parity_count;
		if (cmd == hes_pkg::CMD_CHECK) begin
			res.code_word   = '0;
			res.syndrome    = chk;
			res.error_found = (chk != '0);
		end else begin
			res.code_word   = word | par_pos;
			res.syndrome    = '0;
			res.error_found = 1'b0;
		end
	end

endmodule

// ===== rtl/hamming_encode_and_syndrome.sv =====
// Top level of the Hamming encoder and syndrome checker with its stream ports.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: payload[62:0]; tuser: cmd
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: code_word, syndrome,
//           |     |                               |        error_found, parity_count
//  cfg      | in  | cfg_wen (no wait)             | cfg_wdata: data_len
//
// One item per cycle sustained while m_axis_tready stays high; an accepted item passes the
// input register, then the parity trees, then the result register, which drives m_axis.
// Reset (arst_n low) empties both stages and sets data_len to 57.
// A stall at m_axis holds the result register; the input register takes an item while it is
// empty, or while the result stage is free or is being drained in the same cycle.
// data_len is to be written only while no item is in flight; the block does not enforce this.
module hamming_encode_and_syndrome #(
	parameter int MAX_DATA_BITS = 57
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic [5:0]  cfg_wdata,     // data_len
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [62:0] payload, [63] zero
	input  logic        s_axis_tuser,  // cmd: 0 encode, 1 check
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // [62:0] code_word, [68:63] syndrome,
	                                   // [69] error_found, [72:70] parity_count, [79:73] zero
);

	hes_pkg::cfg_t cfg;
	hes_pkg::res_t res;

	logic                       valid_s1;
	logic                       cmd_s1;
	logic [hes_pkg::WORD_W-1:0] payload_s1;
	logic                       valid_s2;
	hes_pkg::res_t              res_s2;

	logic adv;       // result stage can take what stage 1 holds
	logic s_accept;

	hes_cfg #(
		.MAX_DATA_BITS(MAX_DATA_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	assign adv           = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1     <= s_axis_tuser;
			payload_s1 <= s_axis_tdata[hes_pkg::WORD_W-1:0];
		end
	end

	hes_core u_core (
		.cmd    (cmd_s1),
		.payload(payload_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'b0, res_s2.parity_count, res_s2.error_found,
	                        res_s2.syndrome, res_s2.code_word};

	// a check item moved to the result stage never carries a codeword
	a_check_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && cmd_s1 == hes_pkg::CMD_CHECK) |=> (res_s2.code_word == '0))
		else $error("check item produced a nonzero codeword");

	// an encode item moved to the result stage never flags an error
	a_encode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && cmd_s1 == hes_pkg::CMD_ENCODE)
		|=> (!res_s2.error_found && res_s2.syndrome == '0))
		else $error("encode item produced a syndrome");

	// a stage-1 item blocked by a full result stage stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(payload_s1) && $stable(cmd_s1)))
		else $error("stage 1 item changed while stalled");

endmodule

// ===== dv/tb_hamming_encode_and_syndrome.sv =====
// Self-checking testbench for hamming_encode_and_syndrome: random and directed items, scoreboarded.
module tb_hamming_encode_and_syndrome;
	timeunit 1ns;
	timeprecision 1ps;

	// Scoreboard: own copy of data_len, predicts each item's result and
	// matches results against the oldest pending prediction.
	class codeword_scoreboard;
		logic [hes_pkg::LEN_W-1:0] data_len;
		hes_pkg::res_t             pending_words[$];
		int                        mismatches;
		int                        results_seen;
		int                        encodes;
		int                        checks;

		function new();
			data_len     = hes_pkg::LEN_W'(57);
			mismatches   = 0;
			results_seen = 0;
			encodes      = 0;
			checks       = 0;
		endfunction

		// data_len as the block uses it: zero reads as one, saturates at 57
		function int used_len();
			int n;
			n = int'(data_len);
			if (n < 1) n = 1;
			if (n > hes_pkg::DATA_CAP) n = hes_pkg::DATA_CAP;
			return n;
		endfunction

		function int parity_len(int n);
			int p;
			p = 1;
			while (p < hes_pkg::SYN_W && (1 << p) < n + p + 1) p++;
			return p;
		endfunction

		function int positions();
			return used_len() + parity_len(used_len());
		endfunction

		// D_i over positions 1..total, bit k-1 holding position k
		function logic [hes_pkg::SYN_W-1:0] parity_checks(logic [hes_pkg::WORD_W-1:0] w,
			int total, int p);
			logic [hes_pkg::SYN_W-1:0] d;
			d = '0;
			for (int i = 0; i < p; i++)
				for (int k = 1; k <= total; k++)
					if ((k >> i) & 1) d[i] = d[i] ^ w[k-1];
			return d;
		endfunction

		function hes_pkg::res_t predict_hamming(logic cmd, logic [hes_pkg::WORD_W-1:0] payload);
			hes_pkg::res_t              r;
			int                         n;
			int                         p;
			int                         total;
			int                         d;
			logic [hes_pkg::WORD_W-1:0] w;
			logic [hes_pkg::SYN_W-1:0]  syn;
			n     = used_len();
			p     = parity_len(n);
			total = n + p;
			w     = '0;
			r     = '0;
			if (cmd == hes_pkg::CMD_ENCODE) begin
				// data bits fill the non-power-of-two positions, lowest first
				d = 0;
				for (int k = 1; k <= total; k++) begin
					if ((k & (k - 1)) != 0 && d < n) begin
						w[k-1] = payload[d];
						d++;
					end
				end
				syn = parity_checks(w, total, p);
				for (int i = 0; i < p; i++) w[(1 << i) - 1] = syn[i];
				r.code_word = w;
			end else begin
				// positions above n+p are ignored
				for (int k = 0; k < total; k++) w[k] = payload[k];
				syn           = parity_checks(w, total, p);
				r.syndrome    = syn;
				r.error_found = (syn != '0);
			end
			r.parity_count = hes_pkg::PCNT_W'(p);
			return r;
		endfunction

		function void note_item(logic cmd, logic [hes_pkg::WORD_W-1:0] payload);
			pending_words = {pending_words, predict_hamming(cmd, payload)};
			if (cmd == hes_pkg::CMD_ENCODE) encodes++;
			else checks++;
		endfunction

		function void check_item(logic [79:0] t);
			hes_pkg::res_t e;
			results_seen++;
			if (pending_words.size() == 0) begin
				$error("result item arrived with no prediction pending");
				mismatches++;
				return;
			end
			e = pending_words.pop_front();
			if (t[62:0] !== e.code_word) begin
				$error("code_word: expected %h, got %h", e.code_word, t[62:0]);
				mismatches++;
			end
			if (t[68:63] !== e.syndrome) begin
				$error("syndrome: expected %0d, got %0d", e.syndrome, t[68:63]);
				mismatches++;
			end
			if (t[69] !== e.error_found) begin
				$error("error_found: expected %0d, got %0d", e.error_found, t[69]);
				mismatches++;
			end
			if (t[72:70] !== e.parity_count) begin
				$error("parity_count: expected %0d, got %0d", e.parity_count, t[72:70]);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	logic [5:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [62:0] payload, [63] zero
	logic        s_axis_tuser;   // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // [62:0] code_word, [68:63] syndrome, [69] error_found,
	                             // [72:70] parity_count, [79:73] zero

	codeword_scoreboard sb;
	bit                 steady = 1'b0;  // set: neither side idles
	int                 lens_seen = 0;

	hamming_encode_and_syndrome dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #6 clk = ~clk;

	function automatic logic [hes_pkg::WORD_W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[hes_pkg::WORD_W-1:0];
	endfunction

	// Offer one item; returns right after the edge that accepted it.
	// Callers always enter just after a rising edge.
	task automatic send_item(input logic cmd, input logic [hes_pkg::WORD_W-1:0] payload);
		// random gap: tvalid low for whole cycles, never dropped and raised in one step
		while (!steady && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, payload};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(cmd, payload);
	endtask

	// Random item: half of them real codewords with 0..2 flipped positions,
	// the rest plain encodes and raw noise.
	task automatic send_random_item();
		int                         sel;
		int                         total;
		logic [hes_pkg::WORD_W-1:0] w;
		logic [hes_pkg::WORD_W-1:0] low_mask;
		hes_pkg::res_t              enc;
		sel   = $urandom_range(0, 99);
		total = sb.positions();
		w     = rand_word();
		if (sel < 35) begin
			send_item(hes_pkg::CMD_ENCODE, w);
		end else if (sel < 85) begin
			enc = sb.predict_hamming(hes_pkg::CMD_ENCODE, w);
			w   = enc.code_word;
			repeat ($urandom_range(0, 2)) w[$urandom_range(0, total - 1)] ^= 1'b1;
			// junk above the last position must not change the syndrome
			if ($urandom_range(0, 4) == 0) begin
				low_mask = {hes_pkg::WORD_W{1'b1}} >> (hes_pkg::WORD_W - total);
				w        = w | (rand_word() & ~low_mask);
			end
			send_item(hes_pkg::CMD_CHECK, w);
		end else begin
			send_item(hes_pkg::CMD_CHECK, w);
		end
	endtask

	// Wait until every prediction has been matched, then idle before returning.
	task automatic wait_drained();
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// data_len write; only called with the pipeline empty
	task automatic write_data_len(input logic [hes_pkg::LEN_W-1:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		sb.data_len = v;
		lens_seen++;
	endtask

	// Receiver: checks each accepted result, stalls at random, and twice
	// holds off for a long stretch so the pipeline backs up into s_axis.
	initial begin
		int hold_left;
		int hold_marks[$];
		hold_left     = 0;
		hold_marks    = '{150, 500};
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) sb.check_item(m_axis_tdata);
			if (hold_marks.size() != 0 && sb.results_seen >= hold_marks[0]) begin
				hold_left = 80;
				void'(hold_marks.pop_front());
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 14) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Main sequence: reset, directed items at the reset length, then one
	// random phase per data_len setting.
	initial begin
		int                         len_plan[13];
		logic [hes_pkg::WORD_W-1:0] cw;
		int                         spots[6];
		hes_pkg::res_t              enc;
		sb            = new();
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = hes_pkg::CMD_ENCODE;
		// out-of-range lengths (0, 58, 63) clamp; -1 picks one at random
		len_plan = '{0, 1, 2, 3, 4, 11, 12, 26, 27, 57, 58, 63, -1};
		spots    = '{1, 2, 3, 4, 32, 63};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, data_len at its reset value of 57 (63 positions)
		send_item(hes_pkg::CMD_ENCODE, '0);
		send_item(hes_pkg::CMD_ENCODE, {hes_pkg::WORD_W{1'b1}});
		send_item(hes_pkg::CMD_ENCODE, {6'h00, {hes_pkg::DATA_CAP{1'b1}}});
		// only ignored bits set
		send_item(hes_pkg::CMD_ENCODE, {6'h3F, {hes_pkg::DATA_CAP{1'b0}}});
		send_item(hes_pkg::CMD_ENCODE, 63'h1);
		send_item(hes_pkg::CMD_ENCODE, 63'h1 << 56);
		send_item(hes_pkg::CMD_ENCODE, 63'h5555_5555_5555_5555);
		send_item(hes_pkg::CMD_CHECK, '0);
		send_item(hes_pkg::CMD_CHECK, {hes_pkg::WORD_W{1'b1}});
		enc = sb.predict_hamming(hes_pkg::CMD_ENCODE, rand_word());
		cw  = enc.code_word;
		send_item(hes_pkg::CMD_CHECK, cw);
		// single errors on parity and data positions, first and last
		foreach (spots[i]) send_item(hes_pkg::CMD_CHECK, cw ^ (63'h1 << (spots[i] - 1)));
		// double errors: positions 2 and 3 alias position 1; 1 and 63 alias 62
		send_item(hes_pkg::CMD_CHECK, cw ^ 63'h6);
		send_item(hes_pkg::CMD_CHECK, cw ^ (63'h1 | (63'h1 << 62)));
		repeat (40) send_random_item();
		s_axis_tvalid <= 1'b0;
		wait_drained();

		foreach (len_plan[ph]) begin
			if (len_plan[ph] < 0) write_data_len(hes_pkg::LEN_W'($urandom_range(5, 56)));
			else write_data_len(hes_pkg::LEN_W'(len_plan[ph]));
			steady = (ph == 4);  // one phase with no idling on either side
			repeat (55) send_random_item();
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end
		steady = 1'b0;

		repeat (10) @(posedge clk);
		$display("Ran %0d encode and %0d check items over %0d data_len settings,",
			sb.encodes, sb.checks, lens_seen + 1);
		$display("zero and saturating lengths included; %0d results compared, %0d mismatches.",
			sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/hes_pkg.sv
rtl/hes_cfg.sv
rtl/hes_core.sv
rtl/hamming_encode_and_syndrome.sv
dv/tb_hamming_encode_and_syndrome.sv
